>>> sv/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int OperandWidth = 16;
  localparam int ProdWidth    = 2 * OperandWidth;
  localparam int MagWidth     = ProdWidth + 1;
  localparam int ResNumWidth  = 33;
  localparam int ResDenWidth  = 32;
  localparam int CntWidth     = $clog2(MagWidth + 1);
  localparam int QueueDepth   = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // One classified item handed from front to back.
  typedef struct packed {
    logic                num_neg;
    logic [MagWidth-1:0] num_mag;
    logic [MagWidth-1:0] den_mag;
  } job_t;

endpackage

>>> sv/rau_front.sv
// Front end: takes an item, forms the cross products and sums as sign/magnitude.
module rau_front import rau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic [OperandWidth-1:0] a_num,
  input  logic [OperandWidth-1:0] a_den,
  input  logic [OperandWidth-1:0] b_num,
  input  logic [OperandWidth-1:0] b_den,
  output logic                    job_valid,
  input  logic                    job_ready,
  output job_t                    job
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_SUM  = 3'b100
  } fstate_t;

  fstate_t state;
  op_t     op;
  logic [OperandWidth-1:0] an, ad, bn, bd;
  logic an_n, ad_n, bn_n, bd_n;
  logic [ProdWidth-1:0] p0, p1, pd;
  logic p0_n, p1_n, pd_n;

  // Magnitude of a two's complement operand.
  function automatic logic [OperandWidth-1:0] mag(input logic [OperandWidth-1:0] v);
    return v[OperandWidth-1] ? (~v + 1'b1) : v;
  endfunction

  logic [OperandWidth-1:0] x0, y0, x1, y1, xd, yd;
  logic x0n, y0n, x1n, y1n, xdn, ydn;
  always_comb begin
    x0 = an; x0n = an_n; x1 = bn; x1n = bn_n; xd = ad; xdn = ad_n;
    y0 = bd; y0n = bd_n; y1 = ad; y1n = ad_n; yd = bd; ydn = bd_n;
    case (op)
      OP_MUL: begin
        y0 = bn; y0n = bn_n;
      end
      OP_DIV: begin
        yd = bn; ydn = bn_n;
      end
      default: ;
    endcase
  end

  // Signed sum or difference of the two numerator products; p0 alone for multiply and divide.
  logic s1n;
  logic [MagWidth-1:0] sm;
  logic sn;
  always_comb begin
    s1n = (op == OP_SUB) ? ~p1_n : p1_n;
    if (op == OP_MUL || op == OP_DIV) begin
      sm = {1'b0, p0};
      sn = p0_n;
    end else if (p0_n == s1n) begin
      sm = {1'b0, p0} + {1'b0, p1};
      sn = p0_n;
    end else if (p0 >= p1) begin
      sm = {1'b0, p0 - p1};
      sn = p0_n;
    end else begin
      sm = {1'b0, p1 - p0};
      sn = s1n;
    end
    if (sm == '0) sn = 1'b0;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= op_t'(opcode);
            an <= mag(a_num); an_n <= a_num[OperandWidth-1];
            ad <= mag(a_den); ad_n <= a_den[OperandWidth-1];
            bn <= mag(b_num); bn_n <= b_num[OperandWidth-1];
            bd <= mag(b_den); bd_n <= b_den[OperandWidth-1];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p0 <= ProdWidth'(x0) * ProdWidth'(y0); p0_n <= x0n ^ y0n;
          p1 <= ProdWidth'(x1) * ProdWidth'(y1); p1_n <= x1n ^ y1n;
          pd <= ProdWidth'(xd) * ProdWidth'(yd); pd_n <= xdn ^ ydn;
          state <= S_SUM;
        end
        S_SUM: begin
          if (!job_valid || job_ready) begin
            job_valid   <= 1'b1;
            job.num_mag <= sm;
            // A zero denominator carries no sign.
            job.num_neg <= sn ^ (pd_n && (pd != '0));
            job.den_mag <= {1'b0, pd};
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (job_valid && job_ready && state != S_SUM) job_valid <= 1'b0;
    end
  end

endmodule

>>> sv/rau_queue.sv
// Short item queue between the front and back ends.
module rau_queue import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int PtrW = $clog2(QueueDepth);
  job_t slots [QueueDepth];
  logic [PtrW-1:0] wp, rp;
  logic [PtrW:0]   count;
  logic wr, rd;

  assign wr_ready = (count != (PtrW+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wr_data;
  end

endmodule

>>> sv/rau_back.sv
// Back end: Euclid gcd by shared restoring divider, then two reducing divisions.
module rau_back import rau_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  job_t                   job,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [ResNumWidth-1:0] res_num,
  output logic [ResDenWidth-1:0] res_den,
  output logic                   res_zero
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_GCD  = 5'b00010,
    B_DNUM = 5'b00100,
    B_DDEN = 5'b01000,
    B_DONE = 5'b10000
  } bstate_t;

  bstate_t state;
  logic                num_neg;
  logic [MagWidth-1:0] num, den, q, g, qn;
  // Divider: one quotient bit per cycle.
  logic [MagWidth-1:0] dvd, dvs, rem, quo;
  logic [CntWidth-1:0] cnt;
  logic                dbusy;
  logic [MagWidth:0]   trial;
  logic [MagWidth-1:0] rem_sh;

  assign rem_sh = {rem[MagWidth-2:0], dvd[MagWidth-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};
  assign job_ready = (state == B_IDLE);
  assign res_valid = (state == B_DONE);

  logic [ResNumWidth-1:0] rn;
  logic [ResDenWidth-1:0] rd;
  logic                   zd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      dbusy     <= 1'b0;
    end else begin
      if (dbusy) begin
        rem <= trial[MagWidth] ? rem_sh : trial[MagWidth-1:0];
        quo <= {quo[MagWidth-2:0], ~trial[MagWidth]};
        dvd <= {dvd[MagWidth-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) dbusy <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            num_neg <= job.num_neg;
            num     <= job.num_mag;
            den     <= job.den_mag;
            if (job.den_mag == '0) begin
              rn <= job.num_neg ? ResNumWidth'(~job.num_mag + 1'b1)
                                : ResNumWidth'(job.num_mag);
              rd <= '0; zd <= 1'b1;
              state <= B_DONE;
            end else if (job.num_mag == '0) begin
              rn <= '0; rd <= ResDenWidth'(1); zd <= 1'b0;
              state <= B_DONE;
            end else begin
              q <= job.den_mag;
              dvd <= job.num_mag; dvs <= job.den_mag;
              rem <= '0; cnt <= CntWidth'(MagWidth); dbusy <= 1'b1;
              state <= B_GCD;
            end
          end
        end
        B_GCD: begin
          // Each finished division gives p mod q; step until remainder is zero.
          if (!dbusy) begin
            if (rem == '0) begin
              g <= q;
              dvd <= num; dvs <= q; rem <= '0;
              cnt <= CntWidth'(MagWidth); dbusy <= 1'b1;
              state <= B_DNUM;
            end else begin
              q <= rem;
              dvd <= q; dvs <= rem; rem <= '0;
              cnt <= CntWidth'(MagWidth); dbusy <= 1'b1;
            end
          end
        end
        B_DNUM: begin
          if (!dbusy) begin
            qn <= quo;
            dvd <= den; dvs <= g; rem <= '0;
            cnt <= CntWidth'(MagWidth); dbusy <= 1'b1;
            state <= B_DDEN;
          end
        end
        B_DDEN: begin
          if (!dbusy) begin
            rn <= num_neg ? ResNumWidth'(~qn + 1'b1) : ResNumWidth'(qn);
            rd <= ResDenWidth'(quo);
            zd <= 1'b0;
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (res_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign res_num  = rn;
  assign res_den  = rd;
  assign res_zero = zd;

endmodule

>>> sv/rau_out.sv
// Output register stage holding one result item for the master side.
module rau_out import rau_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ResNumWidth-1:0] in_num,
  input  logic [ResDenWidth-1:0] in_den,
  input  logic                   in_zero,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ResNumWidth-1:0] res_num,
  output logic [ResDenWidth-1:0] res_den,
  output logic                   zero_den
);

  // The register takes a new item when empty or when its item leaves.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_num  <= in_num;
      res_den  <= in_den;
      zero_den <= in_zero;
    end
  end

endmodule

>>> sv/rational_arith_unit.sv
// Top level of the rational arithmetic unit.
// Each item takes two signed 16-bit fractions and an opcode and returns one
// result: the exact sum, difference, product or quotient reduced by the gcd,
// with the sign on the numerator and a positive denominator. A zero result
// numerator over a nonzero denominator gives 0/1. A zero result denominator
// skips reduction: the flag zero_denominator is set, the numerator is the
// unreduced signed value and the denominator is zero. The front end takes an
// item, multiplies and combines (S_IDLE, S_MUL, S_SUM) and passes it through a
// two-entry queue, so it can take the next item while the back end works. The
// back end works on one item at a time: it takes the item, runs each Euclid
// step and each of the two reducing divisions on one shared restoring divider,
// then hands the result to the output register. An item with a zero numerator
// or denominator skips the divider and goes straight to the handoff. The
// output register holds one result, so the back end can take its next item
// while a result waits.
module rational_arith_unit import rau_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0], a_numerator[17:2], a_denominator[33:18],
  // b_numerator[49:34], b_denominator[65:50], zeros to 71
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // res_numerator[32:0], res_denominator[64:33], zero_denominator[65], zeros
  output logic [71:0]  m_tdata
);

  logic jf_valid, jf_ready, jb_valid, jb_ready;
  job_t jf, jb;

  rau_front u_front (
    .clk, .rst,
    .in_valid (s_tvalid), .in_ready (s_tready),
    .opcode (s_tdata[1:0]),
    .a_num (s_tdata[17:2]), .a_den (s_tdata[33:18]),
    .b_num (s_tdata[49:34]), .b_den (s_tdata[65:50]),
    .job_valid (jf_valid), .job_ready (jf_ready), .job (jf)
  );

  rau_queue u_queue (
    .clk, .rst,
    .wr_valid (jf_valid), .wr_ready (jf_ready), .wr_data (jf),
    .rd_valid (jb_valid), .rd_ready (jb_ready), .rd_data (jb)
  );

  // Back end: reduced numerator, denominator and flag.
  logic                   r_valid, r_ready, r_zero;
  logic [ResNumWidth-1:0] r_num;
  logic [ResDenWidth-1:0] r_den;
  rau_back u_back (
    .clk, .rst,
    .job_valid (jb_valid), .job_ready (jb_ready), .job (jb),
    .res_valid (r_valid), .res_ready (r_ready),
    .res_num (r_num), .res_den (r_den), .res_zero (r_zero)
  );

  // Output register on the master side.
  rau_out u_out (
    .clk, .rst,
    .in_valid (r_valid), .in_ready (r_ready),
    .in_num (r_num), .in_den (r_den), .in_zero (r_zero),
    .out_valid (m_tvalid), .out_ready (m_tready),
    .res_num (m_tdata[32:0]), .res_den (m_tdata[64:33]), .zero_den (m_tdata[65])
  );

  assign m_tdata[71:66] = '0;

  // A result is never offered with both zero flag and nonzero denominator.
  a_zd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[65] |-> m_tdata[64:33] == '0) else $error("zd den");
  // A reduced result always has a nonzero denominator.
  a_den: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[65] |-> m_tdata[64:33] != '0) else $error("den zero");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");

endmodule

>>> tb/tb_top.sv
// Testbench for the rational arithmetic unit: directed table plus random items.
`timescale 1ns / 1ps

module tb_top import rau_pkg::*; ();

  localparam int WatchdogLimit = 20000;
  localparam int RandomItems   = 800;

  typedef struct {
    op_t                opcode;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
    logic               has_fixed;
    logic [32:0]        fixed_num;
    logic [31:0]        fixed_den;
    logic               fixed_zero;
  } stim_row_t;

  typedef struct {
    logic [32:0] num;
    logic [31:0] den;
    logic        zero_den;
  } fraction_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  fraction_t   expected_fracs[$];
  int          failures = 0;
  int          idle_cycles = 0;
  bit          sending_done = 1'b0;

  rational_arith_unit dut (.*);

  always #5 clk = ~clk;

  // Euclid's remainder loop on magnitudes.
  function automatic longint unsigned gcd_of(longint unsigned p, longint unsigned q);
    longint unsigned t;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p;
  endfunction

  // Exact cross product, then reduction with the sign on the numerator.
  function automatic fraction_t reduce_fraction(op_t op, logic signed [15:0] an,
      logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
    fraction_t r;
    longint num, den;
    longint unsigned num_mag, den_mag, g;
    logic num_neg;
    case (op)
      OP_ADD: begin
        num = longint'(an) * bd + longint'(bn) * ad; den = longint'(ad) * bd;
      end
      OP_SUB: begin
        num = longint'(an) * bd - longint'(bn) * ad; den = longint'(ad) * bd;
      end
      OP_MUL: begin
        num = longint'(an) * bn; den = longint'(ad) * bd;
      end
      default: begin
        num = longint'(an) * bd; den = longint'(ad) * bn;
      end
    endcase
    num_neg = (num < 0) != (den < 0);
    num_mag = (num < 0) ? -num : num;
    den_mag = (den < 0) ? -den : den;
    if (den_mag == 0) begin
      r.num = num[32:0];
      r.den = '0;
      r.zero_den = 1'b1;
    end else if (num_mag == 0) begin
      r.num = '0;
      r.den = 32'd1;
      r.zero_den = 1'b0;
    end else begin
      g = gcd_of(num_mag, den_mag);
      num = longint'(num_mag / g);
      if (num_neg) num = -num;
      r.num = num[32:0];
      r.den = 32'(den_mag / g);
      r.zero_den = 1'b0;
    end
    return r;
  endfunction

  // Offer one item and wait until it is taken, with a random gap first.
  task automatic send_item(op_t op, logic signed [15:0] an, logic signed [15:0] ad,
      logic signed [15:0] bn, logic signed [15:0] bd);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, bd, bn, ad, an, op};
    expected_fracs.push_back(reduce_fraction(op, an, ad, bn, bd));
    do @(posedge clk); while (!s_tready);
  endtask

  // Operands drawn from extremes, small values or the full range.
  function automatic logic signed [15:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      3: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t directed_rows[] = '{
    '{OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, 33'd5, 32'd6, 1'b0},
    '{OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, 33'd0, 32'd1, 1'b0},
    '{OP_MUL, 16'sd0, 16'sd5, 16'sd3, 16'sd7, 1'b1, 33'd0, 32'd1, 1'b0},
    '{OP_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5, 1'b1, 33'd15, 32'd0, 1'b1},
    '{OP_ADD, 16'sd3, 16'sd0, 16'sd1, 16'sd1, 1'b1, 33'd3, 32'd0, 1'b1},
    '{OP_MUL, 16'sd2, 16'sd0, 16'sd3, 16'sd0, 1'b1, 33'd6, 32'd0, 1'b1},
    '{OP_MUL, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b1, 33'd1, 32'd1, 1'b0},
    '{OP_MUL, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b1, -33'sd1, 32'd1, 1'b0},
    '{OP_DIV, 16'sd1, -16'sd2, 16'sd1, 16'sd1, 1'b1, -33'sd1, 32'd2, 1'b0},
    '{OP_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1, 1'b1, 33'h040000000, 32'd1, 1'b0},
    '{OP_ADD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, '0, '0, 1'b0},
    '{OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, '0, '0, 1'b0},
    '{OP_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, '0, '0, 1'b0},
    '{OP_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, '0, '0, 1'b0},
    '{OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0, '0, 1'b0},
    '{OP_SUB, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1, 33'd0, 32'd1, 1'b0},
    '{OP_DIV, 16'shffff, 16'sh5555, 16'shaaaa, 16'sh00ff, 1'b0, '0, '0, 1'b0},
    '{OP_ADD, 16'sh5555, 16'shff00, 16'sh00ff, 16'shaaaa, 1'b0, '0, '0, 1'b0}
  };

  // Stimulus: reset, directed table, then random items.
  initial begin
    fraction_t fixed;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].opcode, directed_rows[i].a_num, directed_rows[i].a_den,
                directed_rows[i].b_num, directed_rows[i].b_den);
      if (directed_rows[i].has_fixed) begin
        fixed.num = directed_rows[i].fixed_num;
        fixed.den = directed_rows[i].fixed_den;
        fixed.zero_den = directed_rows[i].fixed_zero;
        expected_fracs[$] = fixed;
      end
    end
    for (int n = 0; n < RandomItems; n++) begin
      send_item(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
    end
    s_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver stalls, with one long hold-off early on to fill the queue.
  initial begin
    int stall;
    @(negedge rst);
    repeat (20) @(posedge clk);
    m_tready <= 1'b0;
    repeat (2000) @(posedge clk);
    forever begin
      @(posedge clk);
      stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) stall = 0;
      m_tready <= 1'b1;
      @(posedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  // Result checking against the oldest waiting expectation.
  always @(posedge clk) begin
    fraction_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fracs.size() == 0) begin
        $error("result with no expectation waiting: %h", m_tdata);
        failures++;
      end else begin
        want = expected_fracs.pop_front();
        if (m_tdata[32:0] !== want.num) begin
          $error("res_numerator expected %h actual %h", want.num, m_tdata[32:0]);
          failures++;
        end
        if (m_tdata[64:33] !== want.den) begin
          $error("res_denominator expected %h actual %h", want.den, m_tdata[64:33]);
          failures++;
        end
        if (m_tdata[65] !== want.zero_den) begin
          $error("zero_denominator expected %b actual %b", want.zero_den, m_tdata[65]);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles in which nothing is accepted.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // End of run: everything sent, nothing outstanding, then a short drain.
  initial begin
    wait (sending_done);
    while (expected_fracs.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
